// ----- design/pea_pkg.sv -----
// shared constants and tables for the pointing error angle pipeline
package pea_pkg;

    localparam int POS_W       = 32;
    localparam int QUAT_W      = 16;
    localparam int DIST_W      = 16;
    localparam int ANGLE_W     = 16;
    localparam int RAD_W       = 59;
    localparam int ROOT_W      = 29;
    localparam int SQRT_STAGES = 29;
    localparam int SIDE_W      = 64;
    localparam int DOT_W       = 60;
    localparam int N_W         = 27;
    localparam int C_W         = 30;
    localparam int DIV_BITS    = 29;
    localparam int CORDIC_N    = 31;
    localparam int XY_W        = 32;
    localparam int Z_W         = 34;
    localparam int XB_W        = 32;
    localparam int MAG_W       = 26;

    localparam logic [ROOT_W-1:0]    ONE_Q28         = 29'h1000_0000;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30    = 34'sd1686629714;
    localparam logic [29:0]          DEG_PER_RAD_Q24 = 30'd961263669;
    localparam logic [ANGLE_W-1:0]   MAX_ANGLE       = 16'd46080;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            5'd0:    r = 34'sd843314857;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043837;
            5'd3:    r = 34'sd133525159;
            5'd4:    r = 34'sd67021687;
            5'd5:    r = 34'sd33543516;
            5'd6:    r = 34'sd16775851;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194283;
            5'd9:    r = 34'sd2097149;
            default: r = Z_W'(34'sd1 <<< (5'd30 - i));
        endcase
        return r;
    endfunction

endpackage

// ----- design/pea_isqrt.sv -----
// pipelined integer square root, one result bit per stage, with sideband
module pea_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [pea_pkg::RAD_W-1:0]  radicand,
    input  logic [pea_pkg::SIDE_W-1:0] side_in,
    output logic                       out_valid,
    output logic [pea_pkg::ROOT_W-1:0] root,
    output logic [pea_pkg::SIDE_W-1:0] side_out
);
    import pea_pkg::*;

    logic [RAD_W-1:0]  v_reg    [SQRT_STAGES+1];
    logic [RAD_W-1:0]  r_reg    [SQRT_STAGES+1];
    logic [SIDE_W-1:0] side_reg [SQRT_STAGES+1];
    logic              valid_reg[SQRT_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0]    <= radicand;
            r_reg[0]    <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 1; j <= SQRT_STAGES; j++)
    begin : g_stage
        localparam logic [RAD_W-1:0] B = RAD_W'(1) << (2 * (SQRT_STAGES - j));
        logic [RAD_W-1:0] trial;
        logic [RAD_W-1:0] v_next;
        logic [RAD_W-1:0] r_next;

        always_comb
        begin
            trial = r_reg[j-1] + B;
            if (v_reg[j-1] >= trial)
            begin
                v_next = v_reg[j-1] - trial;
                r_next = (r_reg[j-1] >> 1) + B;
            end
            else
            begin
                v_next = v_reg[j-1];
                r_next = r_reg[j-1] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[j]    <= v_next;
                r_reg[j]    <= r_next;
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES];
    assign root      = r_reg[SQRT_STAGES][ROOT_W-1:0];
    assign side_out  = side_reg[SQRT_STAGES];

endmodule

// ----- design/pea_front.sv -----
// line of sight, distance test, scaling, rotated axis, dot product and squares
module pea_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [pea_pkg::POS_W-1:0]  viewer_x,
    input  logic signed [pea_pkg::POS_W-1:0]  viewer_y,
    input  logic signed [pea_pkg::POS_W-1:0]  viewer_z,
    input  logic signed [pea_pkg::POS_W-1:0]  leader_x,
    input  logic signed [pea_pkg::POS_W-1:0]  leader_y,
    input  logic signed [pea_pkg::POS_W-1:0]  leader_z,
    input  logic signed [pea_pkg::QUAT_W-1:0] quat_x,
    input  logic signed [pea_pkg::QUAT_W-1:0] quat_y,
    input  logic signed [pea_pkg::QUAT_W-1:0] quat_z,
    input  logic signed [pea_pkg::QUAT_W-1:0] quat_w,
    input  logic [pea_pkg::DIST_W-1:0]        min_distance,
    output logic                              out_valid,
    output logic [pea_pkg::RAD_W-1:0]         sumsq,
    output logic signed [pea_pkg::DOT_W-1:0]  dot,
    output logic                              close
);
    import pea_pkg::*;

    logic              v_reg [1:7];

    // stage 1
    logic signed [POS_W:0]    d1_reg [3];
    logic signed [QUAT_W-1:0] qx1_reg, qy1_reg, qz1_reg, qw1_reg;
    // stage 2
    logic [POS_W-1:0]         m2_reg [3];
    logic                     neg2_reg [3];
    logic                     small2_reg;
    logic signed [31:0]       pyy2_reg, pzz2_reg, pxy2_reg, pwz2_reg, pxz2_reg, pwy2_reg;
    logic [31:0]              mdsq2_reg;
    // stage 3
    logic [31:0]              msq3_reg [3];
    logic [POS_W-1:0]         m3_reg [3];
    logic                     neg3_reg [3];
    logic                     small3_reg;
    logic [31:0]              mdsq3_reg;
    logic signed [XB_W-1:0]   xb3_reg [3];
    logic [POS_W-1:0]         mx3_reg;
    // stage 4
    logic [POS_W-1:0]         m4_reg [3];
    logic                     neg4_reg [3];
    logic signed [XB_W-1:0]   xb4_reg [3];
    logic                     close4_reg;
    logic [4:0]               p4_reg;
    // stage 5
    logic [MAG_W-1:0]         a5_reg [3];
    logic                     neg5_reg [3];
    logic signed [XB_W-1:0]   xb5_reg [3];
    logic                     close5_reg;
    // stage 6
    logic [2*MAG_W-1:0]       sq6_reg [3];
    logic signed [XB_W+MAG_W:0] pr6_reg [3];
    logic                     close6_reg;
    // stage 7
    logic [RAD_W-1:0]         sumsq7_reg;
    logic signed [DOT_W-1:0]  dot7_reg;
    logic                     close7_reg;

    logic [POS_W:0]           mag_next [3];
    logic signed [33:0]       s_yz, s_xy, s_xz;
    logic [POS_W-1:0]         mx_next;
    logic [33:0]              sq_sum;
    logic [4:0]               p_next;
    logic [63:0]              sh_next [3];
    logic signed [MAG_W:0]    l_next [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 7; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[1] <= in_valid;
            for (int k = 2; k <= 7; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = d1_reg[i][POS_W] ? -d1_reg[i] : d1_reg[i];
        end
        s_yz = 34'(pyy2_reg) + 34'(pzz2_reg);
        s_xy = 34'(pxy2_reg) + 34'(pwz2_reg);
        s_xz = 34'(pxz2_reg) - 34'(pwy2_reg);
        mx_next = m2_reg[0];
        if (m2_reg[1] > mx_next)
        begin
            mx_next = m2_reg[1];
        end
        if (m2_reg[2] > mx_next)
        begin
            mx_next = m2_reg[2];
        end
        sq_sum = 34'(msq3_reg[0]) + 34'(msq3_reg[1]) + 34'(msq3_reg[2]);
        p_next = '0;
        for (int i = 0; i < POS_W; i++)
        begin
            if (mx3_reg[i])
            begin
                p_next = 5'(i);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (p4_reg > 5'd25)
            begin
                sh_next[i] = 64'(m4_reg[i]) >> (p4_reg - 5'd25);
            end
            else
            begin
                sh_next[i] = 64'(m4_reg[i]) << (5'd25 - p4_reg);
            end
            l_next[i] = neg5_reg[i] ? -$signed({1'b0, a5_reg[i]}) : $signed({1'b0, a5_reg[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            d1_reg[0] <= {leader_x[POS_W-1], leader_x} - {viewer_x[POS_W-1], viewer_x};
            d1_reg[1] <= {leader_y[POS_W-1], leader_y} - {viewer_y[POS_W-1], viewer_y};
            d1_reg[2] <= {leader_z[POS_W-1], leader_z} - {viewer_z[POS_W-1], viewer_z};
            qx1_reg   <= quat_x;
            qy1_reg   <= quat_y;
            qz1_reg   <= quat_z;
            qw1_reg   <= quat_w;
            // stage 2
            for (int i = 0; i < 3; i++)
            begin
                m2_reg[i]   <= mag_next[i][POS_W-1:0];
                neg2_reg[i] <= d1_reg[i][POS_W];
            end
            small2_reg <= (mag_next[0][POS_W:16] == '0) && (mag_next[1][POS_W:16] == '0)
                          && (mag_next[2][POS_W:16] == '0);
            pyy2_reg  <= 32'(qy1_reg) * 32'(qy1_reg);
            pzz2_reg  <= 32'(qz1_reg) * 32'(qz1_reg);
            pxy2_reg  <= 32'(qx1_reg) * 32'(qy1_reg);
            pwz2_reg  <= 32'(qw1_reg) * 32'(qz1_reg);
            pxz2_reg  <= 32'(qx1_reg) * 32'(qz1_reg);
            pwy2_reg  <= 32'(qw1_reg) * 32'(qy1_reg);
            mdsq2_reg <= 32'(min_distance) * 32'(min_distance);
            // stage 3
            for (int i = 0; i < 3; i++)
            begin
                msq3_reg[i] <= 32'(m2_reg[i][15:0]) * 32'(m2_reg[i][15:0]);
                m3_reg[i]   <= m2_reg[i];
                neg3_reg[i] <= neg2_reg[i];
            end
            small3_reg <= small2_reg;
            mdsq3_reg  <= mdsq2_reg;
            xb3_reg[0] <= XB_W'(34'sh1000_0000 - (s_yz <<< 1));
            xb3_reg[1] <= XB_W'(s_xy <<< 1);
            xb3_reg[2] <= XB_W'(s_xz <<< 1);
            mx3_reg    <= mx_next;
            // stage 4
            for (int i = 0; i < 3; i++)
            begin
                m4_reg[i]   <= m3_reg[i];
                neg4_reg[i] <= neg3_reg[i];
                xb4_reg[i]  <= xb3_reg[i];
            end
            close4_reg <= small3_reg && ((sq_sum < 34'(mdsq3_reg)) || (sq_sum == '0));
            p4_reg     <= p_next;
            // stage 5
            for (int i = 0; i < 3; i++)
            begin
                a5_reg[i]   <= sh_next[i][MAG_W-1:0];
                neg5_reg[i] <= neg4_reg[i];
                xb5_reg[i]  <= xb4_reg[i];
            end
            close5_reg <= close4_reg;
            // stage 6
            for (int i = 0; i < 3; i++)
            begin
                sq6_reg[i] <= (2*MAG_W)'(a5_reg[i]) * (2*MAG_W)'(a5_reg[i]);
                pr6_reg[i] <= (XB_W+MAG_W+1)'(xb5_reg[i]) * (XB_W+MAG_W+1)'(l_next[i]);
            end
            close6_reg <= close5_reg;
            // stage 7
            sumsq7_reg <= RAD_W'(sq6_reg[0]) + RAD_W'(sq6_reg[1]) + RAD_W'(sq6_reg[2]);
            dot7_reg   <= DOT_W'(pr6_reg[0]) + DOT_W'(pr6_reg[1]) + DOT_W'(pr6_reg[2]);
            close7_reg <= close6_reg;
        end
    end

    assign out_valid = v_reg[7];
    assign sumsq     = sumsq7_reg;
    assign dot       = dot7_reg;
    assign close     = close7_reg;

endmodule

// ----- design/pea_div.sv -----
// restoring divider for the cosine, one quotient bit per stage, with clamp
module pea_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [pea_pkg::DOT_W-1:0] dot,
    input  logic [pea_pkg::N_W-1:0]          divisor,
    input  logic                             close_in,
    output logic                             out_valid,
    output logic signed [pea_pkg::C_W-1:0]   cosine,
    output logic                             close_out
);
    import pea_pkg::*;

    logic [DOT_W-1:0]    rem_reg   [DIV_BITS+1];
    logic [DIV_BITS-1:0] q_reg     [DIV_BITS+1];
    logic [N_W-1:0]      n_reg     [DIV_BITS+1];
    logic                sign_reg  [DIV_BITS+1];
    logic                sat_reg   [DIV_BITS+1];
    logic                close_reg [DIV_BITS+1];
    logic                valid_reg [DIV_BITS+1];

    logic [DOT_W-1:0]    dot_mag;
    logic [ROOT_W-1:0]   cmag;

    assign dot_mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= dot_mag;
            q_reg[0]     <= '0;
            n_reg[0]     <= divisor;
            sign_reg[0]  <= dot[DOT_W-1];
            sat_reg[0]   <= dot_mag >= (DOT_W'(divisor) << DIV_BITS);
            close_reg[0] <= close_in;
        end
    end

    for (genvar j = 1; j <= DIV_BITS; j++)
    begin : g_stage
        localparam int K = DIV_BITS - j;
        logic [DOT_W-1:0]    sub;
        logic [DOT_W-1:0]    rem_next;
        logic [DIV_BITS-1:0] q_next;

        always_comb
        begin
            sub    = DOT_W'(n_reg[j-1]) << K;
            q_next = q_reg[j-1];
            if (rem_reg[j-1] >= sub)
            begin
                rem_next  = rem_reg[j-1] - sub;
                q_next[K] = 1'b1;
            end
            else
            begin
                rem_next = rem_reg[j-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]   <= rem_next;
                q_reg[j]     <= q_next;
                n_reg[j]     <= n_reg[j-1];
                sign_reg[j]  <= sign_reg[j-1];
                sat_reg[j]   <= sat_reg[j-1];
                close_reg[j] <= close_reg[j-1];
            end
        end
    end

    always_comb
    begin
        if (sat_reg[DIV_BITS] || (q_reg[DIV_BITS] > ONE_Q28))
        begin
            cmag = ONE_Q28;
        end
        else
        begin
            cmag = q_reg[DIV_BITS];
        end
        if (sign_reg[DIV_BITS])
        begin
            cosine = -$signed({1'b0, cmag});
        end
        else
        begin
            cosine = $signed({1'b0, cmag});
        end
    end

    assign out_valid = valid_reg[DIV_BITS];
    assign close_out = close_reg[DIV_BITS];

endmodule

// ----- design/pea_cordic.sv -----
// vectoring cordic for the angle of (cosine, sine) in radians q30
module pea_cordic (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [pea_pkg::C_W-1:0]  cosine,
    input  logic [pea_pkg::ROOT_W-1:0]      sine,
    input  logic                            close_in,
    output logic                            out_valid,
    output logic signed [pea_pkg::Z_W-1:0]  angle,
    output logic                            close_out
);
    import pea_pkg::*;

    logic signed [XY_W-1:0] x_reg     [CORDIC_N+1];
    logic signed [XY_W-1:0] y_reg     [CORDIC_N+1];
    logic signed [Z_W-1:0]  z_reg     [CORDIC_N+1];
    logic                   close_reg [CORDIC_N+1];
    logic                   valid_reg [CORDIC_N+1];

    logic signed [XY_W-1:0] c_ext;
    logic signed [XY_W-1:0] s_ext;

    assign c_ext = XY_W'(cosine);
    assign s_ext = $signed(XY_W'(sine));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    // quarter-turn pre-rotation for a negative cosine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cosine[C_W-1])
            begin
                x_reg[0] <= s_ext;
                y_reg[0] <= -c_ext;
                z_reg[0] <= HALF_PI_Q30;
            end
            else
            begin
                x_reg[0] <= c_ext;
                y_reg[0] <= s_ext;
                z_reg[0] <= '0;
            end
            close_reg[0] <= close_in;
        end
    end

    for (genvar j = 1; j <= CORDIC_N; j++)
    begin : g_stage
        localparam int I = j - 1;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic                   ypos;
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [Z_W-1:0]  z_next;

        always_comb
        begin
            xs   = x_reg[j-1] >>> I;
            ys   = y_reg[j-1] >>> I;
            ypos = !y_reg[j-1][XY_W-1] && (y_reg[j-1] != '0);
            if (ypos)
            begin
                x_next = x_reg[j-1] + ys;
                y_next = y_reg[j-1] - xs;
                z_next = z_reg[j-1] + atan_q30(5'(I));
            end
            else
            begin
                x_next = x_reg[j-1] - ys;
                y_next = y_reg[j-1] + xs;
                z_next = z_reg[j-1] - atan_q30(5'(I));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[j]     <= x_next;
                y_reg[j]     <= y_next;
                z_reg[j]     <= z_next;
                close_reg[j] <= close_reg[j-1];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_N];
    assign angle     = z_reg[CORDIC_N];
    assign close_out = close_reg[CORDIC_N];

endmodule

// ----- design/pointing_error_angle.sv -----
// Pointing error angle between the rotated body x axis and the viewer-to-leader line
// of sight. The block is a fully pipelined datapath: it takes one word per cycle while
// the output is not stalled and returns each result in order, one result per word.
// The depth is set by the two square-root pipelines and the divider (one bit per
// stage each) and the 31-stage cordic. A single enable derived from the output
// register freezes the whole pipeline while a finished result waits, so nothing is
// dropped or repeated; in_ready is high whenever the output register is empty or
// being taken. min_distance resets to 1 and should be written only while idle.
module pointing_error_angle (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [pea_pkg::DIST_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [pea_pkg::POS_W-1:0]   viewer_x,
    input  logic signed [pea_pkg::POS_W-1:0]   viewer_y,
    input  logic signed [pea_pkg::POS_W-1:0]   viewer_z,
    input  logic signed [pea_pkg::POS_W-1:0]   leader_x,
    input  logic signed [pea_pkg::POS_W-1:0]   leader_y,
    input  logic signed [pea_pkg::POS_W-1:0]   leader_z,
    input  logic signed [pea_pkg::QUAT_W-1:0]  quat_x,
    input  logic signed [pea_pkg::QUAT_W-1:0]  quat_y,
    input  logic signed [pea_pkg::QUAT_W-1:0]  quat_z,
    input  logic signed [pea_pkg::QUAT_W-1:0]  quat_w,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pea_pkg::ANGLE_W-1:0]        error_angle,
    output logic                               coincident
);
    import pea_pkg::*;

    logic                     en;
    logic [DIST_W-1:0]        min_distance_reg;

    logic                     fr_valid;
    logic [RAD_W-1:0]         fr_sumsq;
    logic signed [DOT_W-1:0]  fr_dot;
    logic                     fr_close;

    logic                     sq1_valid;
    logic [ROOT_W-1:0]        sq1_root;
    logic [SIDE_W-1:0]        sq1_side;

    logic                     dv_valid;
    logic signed [C_W-1:0]    dv_cos;
    logic                     dv_close;

    logic                     vc_reg;
    logic signed [C_W-1:0]    c_reg;
    logic                     closec_reg;

    logic                     vr_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic signed [C_W-1:0]    cr_reg;
    logic                     closer_reg;
    logic signed [2*C_W-1:0]  csq;

    logic                     sq2_valid;
    logic [ROOT_W-1:0]        sq2_root;
    logic [SIDE_W-1:0]        sq2_side;

    logic                     cd_valid;
    logic signed [Z_W-1:0]    cd_z;
    logic                     cd_close;

    logic                     vp_reg;
    logic [46:0]              plo_reg;
    logic [45:0]              phi_reg;
    logic                     closep_reg;
    logic [Z_W-2:0]           zc;

    logic                     out_valid_reg;
    logic [ANGLE_W-1:0]       angle_reg;
    logic                     coincident_reg;
    logic [63:0]              total;
    logic [17:0]              deg;
    logic [ANGLE_W-1:0]       angle_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= DIST_W'(1);
        end
        else if (cfg_write)
        begin
            min_distance_reg <= cfg_data;
        end
    end

    pea_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .viewer_x     (viewer_x),
        .viewer_y     (viewer_y),
        .viewer_z     (viewer_z),
        .leader_x     (leader_x),
        .leader_y     (leader_y),
        .leader_z     (leader_z),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .quat_w       (quat_w),
        .min_distance (min_distance_reg),
        .out_valid    (fr_valid),
        .sumsq        (fr_sumsq),
        .dot          (fr_dot),
        .close        (fr_close)
    );

    pea_isqrt u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .radicand  (fr_sumsq),
        .side_in   ({3'b000, fr_close, fr_dot}),
        .out_valid (sq1_valid),
        .root      (sq1_root),
        .side_out  (sq1_side)
    );

    pea_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq1_valid),
        .dot       (sq1_side[DOT_W-1:0]),
        .divisor   (sq1_root[N_W-1:0]),
        .close_in  (sq1_side[DOT_W]),
        .out_valid (dv_valid),
        .cosine    (dv_cos),
        .close_out (dv_close)
    );

    assign csq = (2*C_W)'(c_reg) * (2*C_W)'(c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= 1'b0;
            vr_reg        <= 1'b0;
            vp_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg        <= dv_valid;
            vr_reg        <= vc_reg;
            vp_reg        <= cd_valid;
            out_valid_reg <= vp_reg;
        end
    end

    // sine squared is one minus cosine squared
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg      <= dv_cos;
            closec_reg <= dv_close;
            rad_reg    <= RAD_W'((60'd1 << 56) - 60'(csq));
            cr_reg     <= c_reg;
            closer_reg <= closec_reg;
        end
    end

    pea_isqrt u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vr_reg),
        .radicand  (rad_reg),
        .side_in   ({33'd0, closer_reg, cr_reg}),
        .out_valid (sq2_valid),
        .root      (sq2_root),
        .side_out  (sq2_side)
    );

    pea_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq2_valid),
        .cosine    (sq2_side[C_W-1:0]),
        .sine      (sq2_root),
        .close_in  (sq2_side[C_W]),
        .out_valid (cd_valid),
        .angle     (cd_z),
        .close_out (cd_close)
    );

    // radians to degrees, split in two partial products
    assign zc = cd_z[Z_W-1] ? '0 : cd_z[Z_W-2:0];

    always_comb
    begin
        total = (64'(phi_reg) << 17) + 64'(plo_reg) + (64'd1 << 45);
        deg   = total[63:46];
        if (deg > 18'(MAX_ANGLE))
        begin
            angle_next = MAX_ANGLE;
        end
        else
        begin
            angle_next = deg[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg        <= 47'(zc[16:0]) * 47'(DEG_PER_RAD_Q24);
            phi_reg        <= 46'(zc[32:17]) * 46'(DEG_PER_RAD_Q24);
            closep_reg     <= cd_close;
            angle_reg      <= closep_reg ? '0 : angle_next;
            coincident_reg <= closep_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign error_angle = angle_reg;
    assign coincident  = coincident_reg;

endmodule

// ----- design/pea_checker.sv -----
// port-level checks for the pointing error angle block, bound to the top level
module pea_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [pea_pkg::ANGLE_W-1:0] error_angle,
    input logic                        coincident
);
    import pea_pkg::*;

    // a waiting result holds its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(error_angle) && $stable(coincident))
        else $error("result changed while stalled");

    // pipeline freezes while the output waits
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && coincident |-> error_angle == '0)
        else $error("coincident word with nonzero angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> error_angle <= MAX_ANGLE)
        else $error("angle above half turn");

endmodule

bind pointing_error_angle pea_checker u_pea_checker (.*);

// ----- tb/tb.sv -----
// testbench for the pointing error angle pipeline: directed and random words against a predictor
`timescale 1ns / 1ps

module tb;

    import pea_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0]  vx, vy, vz, lx, ly, lz;
        logic signed [QUAT_W-1:0] qx, qy, qz, qw;
    } pose_t;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic               coinc;
    } angle_t;

    class angle_scoreboard;
        angle_t             pending[$];
        logic [DIST_W-1:0]  min_dist;
        int                 errors;
        longint             atan_tab[31] = '{
            843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
            65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
            16, 8, 4, 2, 1};

        function new();
            min_dist = 16'd1;
            errors   = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function void note_word(pose_t p);
            longint d[3], l[3], xb[3], qx, qy, qz, qw, c, x, y, z, xs, ys, t, dot;
            longint unsigned m[3], mx, sq, n, a, deg;
            int rs, ls;
            angle_t e;
            qx = p.qx; qy = p.qy; qz = p.qz; qw = p.qw;
            d[0] = longint'(p.lx) - longint'(p.vx);
            d[1] = longint'(p.ly) - longint'(p.vy);
            d[2] = longint'(p.lz) - longint'(p.vz);
            for (int i = 0; i < 3; i++) m[i] = d[i] < 0 ? -d[i] : d[i];
            if (m[0] < 65536 && m[1] < 65536 && m[2] < 65536)
            begin
                sq = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
                if (sq == 0 || sq < longint'(min_dist) * longint'(min_dist))
                begin
                    e.angle = '0;
                    e.coinc = 1'b1;
                    pending.push_back(e);
                    return;
                end
            end
            mx = m[0];
            if (m[1] > mx) mx = m[1];
            if (m[2] > mx) mx = m[2];
            rs = 0; ls = 0;
            while ((mx >> rs) >= (64'd1 << 26)) rs++;
            while ((mx << ls) < (64'd1 << 25)) ls++;
            for (int i = 0; i < 3; i++)
            begin
                a = (m[i] >> rs) << ls;
                l[i] = d[i] < 0 ? -longint'(a) : longint'(a);
            end
            xb[0] = (64'sd1 <<< 28) - 2 * (qy*qy + qz*qz);
            xb[1] = 2 * (qx*qy + qw*qz);
            xb[2] = 2 * (qx*qz - qw*qy);
            n   = int_sqrt(l[0]*l[0] + l[1]*l[1] + l[2]*l[2]);
            dot = xb[0]*l[0] + xb[1]*l[1] + xb[2]*l[2];
            c   = dot / longint'(n);
            if (c > (64'sd1 <<< 28)) c = 64'sd1 <<< 28;
            if (c < -(64'sd1 <<< 28)) c = -(64'sd1 <<< 28);
            y = int_sqrt((64'd1 << 56) - c*c);
            x = c;
            z = 0;
            if (x < 0)
            begin
                t = x;
                x = y;
                y = -t;
                z = HALF_PI_Q30;
            end
            for (int i = 0; i < 31; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys; y = y - xs; z = z + atan_tab[i];
                end
                else
                begin
                    x = x - ys; y = y + xs; z = z - atan_tab[i];
                end
            end
            if (z < 0) z = 0;
            deg = (longint'(z) * 64'd961263669 + (64'd1 << 45)) >> 46;
            if (deg > 46080) deg = 46080;
            e.angle = deg[15:0];
            e.coinc = 1'b0;
            pending.push_back(e);
        endfunction

        function void check(logic [ANGLE_W-1:0] angle, logic coinc);
            angle_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result angle=%0d coincident=%0d", $time, angle, coinc);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (angle !== e.angle)
            begin
                $display("%0t: error_angle expected %0d actual %0d", $time, e.angle, angle);
                errors++;
            end
            if (coinc !== e.coinc)
            begin
                $display("%0t: coincident expected %0d actual %0d", $time, e.coinc, coinc);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, cfg_write, in_valid, in_ready, out_valid, out_ready, coincident;
    logic [DIST_W-1:0]        cfg_data;
    logic signed [POS_W-1:0]  viewer_x, viewer_y, viewer_z, leader_x, leader_y, leader_z;
    logic signed [QUAT_W-1:0] quat_x, quat_y, quat_z, quat_w;
    logic [ANGLE_W-1:0]       error_angle;

    angle_scoreboard sb = new();
    bit   no_gaps;
    int   idle_cycles;

    pointing_error_angle dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .viewer_x(viewer_x), .viewer_y(viewer_y), .viewer_z(viewer_z),
        .leader_x(leader_x), .leader_y(leader_y), .leader_z(leader_z),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .error_angle(error_angle), .coincident(coincident)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(pose_t p);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        viewer_x <= p.vx; viewer_y <= p.vy; viewer_z <= p.vz;
        leader_x <= p.lx; leader_y <= p.ly; leader_z <= p.lz;
        quat_x <= p.qx; quat_y <= p.qy; quat_z <= p.qz; quat_w <= p.qw;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        sb.note_word(p);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic write_min_dist(logic [DIST_W-1:0] v);
        drain();
        cfg_write <= 1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 0;
        sb.min_dist = v;
    endtask

    function automatic logic signed [QUAT_W-1:0] rand_q();
        return QUAT_W'($urandom_range(0, 32768)) - 16'sd16384;
    endfunction

    function automatic pose_t rand_pose(bit near);
        pose_t p;
        p.vx = $urandom; p.vy = $urandom; p.vz = $urandom;
        if (near)
        begin
            p.lx = p.vx + $signed(POS_W'($urandom_range(0, 1400))) - 700;
            p.ly = p.vy + $signed(POS_W'($urandom_range(0, 1400))) - 700;
            p.lz = p.vz + $signed(POS_W'($urandom_range(0, 1400))) - 700;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            p.lx = p.vx + ($signed($urandom) >>> $urandom_range(0, 31));
            p.ly = p.vy + ($signed($urandom) >>> $urandom_range(0, 31));
            p.lz = p.vz + ($signed($urandom) >>> $urandom_range(0, 31));
        end
        else
        begin
            p.lx = $urandom; p.ly = $urandom; p.lz = $urandom;
        end
        p.qx = rand_q(); p.qy = rand_q(); p.qz = rand_q(); p.qw = rand_q();
        return p;
    endfunction

    function automatic pose_t mk(int vx, int vy, int vz, int lx, int ly, int lz,
                                 int qx, int qy, int qz, int qw);
        pose_t p;
        p.vx = vx; p.vy = vy; p.vz = vz; p.lx = lx; p.ly = ly; p.lz = lz;
        p.qx = QUAT_W'(qx); p.qy = QUAT_W'(qy); p.qz = QUAT_W'(qz); p.qw = QUAT_W'(qw);
        return p;
    endfunction

    initial
    begin
        out_ready <= 0;
        @(posedge rst_n);
        forever
        begin
            int r;
            r = $urandom_range(0, 99);
            if (no_gaps || r < 65) out_ready <= 1;
            else if (r < 95) out_ready <= 0;
            else
            begin
                out_ready <= 0;
                repeat ($urandom_range(10, 60)) @(posedge clk);
                out_ready <= 1;
            end
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check(error_angle, coincident);
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 20000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        pose_t p;
        rst_n = 0; cfg_write = 0; cfg_data = 0; in_valid = 0; no_gaps = 0;
        viewer_x = 0; viewer_y = 0; viewer_z = 0; leader_x = 0; leader_y = 0; leader_z = 0;
        quat_x = 0; quat_y = 0; quat_z = 0; quat_w = 0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset min distance of 1
        send_word(mk(5, 5, 5, 5, 5, 5, 0, 0, 0, 16384));
        send_word(mk(0, 0, 0, 1, 0, 0, 0, 0, 0, 16384));
        send_word(mk(0, 0, 0, -65536, 0, 0, 0, 0, 0, 16384));
        send_word(mk(0, 0, 0, 0, 65536, 0, 0, 0, 16384, 0));
        send_word(mk(-2147483648, -2147483648, -2147483648,
                     2147483647, 2147483647, 2147483647, 16384, 16384, 16384, 16384));
        send_word(mk(2147483647, 0, 2147483647, -2147483648, 0, -2147483648,
                     -16384, -16384, -16384, -16384));
        send_word(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk(0, 0, 0, 7, -3, 2, 0, 0, 0, 0));
        send_word(mk(100, 0, 0, 0, 0, 0, 0, 0, 0, 16384));
        send_word(mk(0, 0, 0, 3, 4, 0, 11585, 0, 0, 11585));
        send_word(mk(0, 0, 0, 0, 0, 1, 0, 16384, 0, 0));
        send_word(mk(1, 2, 3, 65535, -65535, 65535, 3000, -9000, 12000, -5000));
        write_min_dist(0);
        send_word(mk(9, 9, 9, 9, 9, 9, 0, 0, 0, 16384));
        send_word(mk(0, 0, 0, 0, 1, 0, 0, 0, 0, 16384));
        write_min_dist(16'hFFFF);
        send_word(mk(0, 0, 0, 65534, 0, 0, 0, 0, 0, 16384));
        send_word(mk(0, 0, 0, 65535, 0, 0, 0, 0, 0, 16384));
        send_word(mk(0, 0, 0, 40000, 40000, 40000, 0, 0, 0, 16384));
        send_word(mk(0, 0, 0, 65536, 0, 0, 0, 0, 0, -16384));
        write_min_dist(5);
        send_word(mk(0, 0, 0, 3, 4, 0, 0, 0, 0, 16384));
        send_word(mk(0, 0, 0, 3, 3, 0, 0, 0, 0, 16384));

        // random phases through several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_min_dist(1);
                1: write_min_dist(16'($urandom_range(2, 900)));
                2: write_min_dist(0);
                3: write_min_dist(16'hFFFF);
                4: write_min_dist(16'($urandom));
                default: write_min_dist(16'($urandom_range(100, 1200)));
            endcase
            no_gaps = (ph == 2);
            for (int k = 0; k < 255; k++)
            begin
                p = rand_pose($urandom_range(0, 2) == 0);
                send_word(p);
                if (ph == 1 && k == 120)
                begin
                    in_valid <= 0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
            end
        end

        in_valid <= 0;
        no_gaps = 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
